FILE: rtl/core/lsbx_pkg.sv
// ----------------------------------------------------------------------------
// lsbx_pkg: shared types and constants of the LSB byte extractor
// Holds the byte geometry, the bit window size and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbx_pkg;

	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned MAX_TAKE    = 32;
	// Seven carried bits plus up to thirty-two new ones fit in forty.
	localparam int unsigned WIN_BITS    = 40;
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned COUNT_W     = 3;
	localparam int unsigned BPP_W       = 6;

	// One pixel's worth of bytes to be delivered, oldest in slot zero.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] data;
		logic [COUNT_W-1:0]                    count;
		logic                                  end_flag;
	} lsbx_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lsbx_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/core/lsb_stego_byte_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_byte_extractor: hidden byte recovery from pixel low bits
// Gathers the low bits of each pixel into bytes and delivers them in order.
// ----------------------------------------------------------------------------
// Usage. Pixels arrive on in_valid / in_stall with pixel_value; a transaction
// completes at a clock edge with in_valid high and in_stall low. Recovered
// bytes leave on out_valid / out_stall with data_byte, end_found and
// last_of_run; the receiver holds out_stall high to keep a byte waiting.
// The user must write the number of low pixel bits used through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce
// this. It resets to one. The first byte completed after reset is kept as the
// end marker and is not delivered. A later byte equal to it is delivered with
// end_found set, and every pixel after it is accepted and ignored until reset.
// A byte passes through the queue and the output register. Throughput: one
// pixel per cycle while each pixel completes at most one byte and the
// receiver does not stall; the bytes of a pixel that completes several leave
// one by one, and the QUEUE_DEPTH entry queue absorbs such bursts. When the
// queue fills, in_stall rises. Reset is asynchronous; it clears the control
// state at once but not the queue storage or output data, with no clearing
// pass. A stalled receiver only fills the queue; bytes are never dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_byte_extractor #(
	parameter int unsigned PIXEL_BITS  = 32,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [5:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [31:0] pixel_value,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  data_byte,
	output      logic        end_found,
	output      logic        last_of_run
);

	logic                  accept;
	logic                  push;
	logic                  pop;
	lsbx_pkg::lsbx_entry_t push_entry;
	lsbx_pkg::lsbx_entry_t head;
	lsbx_pkg::lsbx_qstat_t stat;

	// Intake stalls only on a full queue, whatever the output side is doing.
	assign in_stall = stat.full;
	assign accept   = in_valid && !in_stall;

	lsbx_front #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.pixel_value (pixel_value),
		.push        (push),
		.push_entry  (push_entry)
	);

	lsbx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (stat)
	);

	lsbx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.data_byte   (data_byte),
		.end_found   (end_found),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

FILE: rtl/core/lsbx_front.sv
// ----------------------------------------------------------------------------
// lsbx_front: pixel intake and byte assembly
// Gathers pixel bits into bytes, captures the end marker and hands the bytes
// of each pixel to the queue as one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_front #(
	parameter int unsigned PIXEL_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [lsbx_pkg::BPP_W-1:0]     cfg_wr_data,
	input  wire logic                           accept,
	input  wire logic [31:0]                    pixel_value,
	output      logic                           push,
	output      lsbx_pkg::lsbx_entry_t          push_entry
);

	localparam logic [31:0] PIX_MASK = 32'((64'd1 << PIXEL_BITS) - 64'd1);
	localparam int unsigned WB = lsbx_pkg::WIN_BITS;
	localparam int unsigned BB = lsbx_pkg::BYTE_BITS;

	logic [lsbx_pkg::BPP_W-1:0] bpp_q;
	logic [BB-1:0]              acc_q;
	logic [2:0]                 cnt_q;
	logic [BB-1:0]              marker_q;
	logic                       captured_q;
	logic                       stopped_q;

	logic [lsbx_pkg::BPP_W-1:0]                        take;
	logic [31:0]                                       taken;
	logic [WB-1:0]                                     win;
	logic [WB-1:0]                                     aligned;
	logic [5:0]                                        len;
	logic [2:0]                                        nbytes;
	logic [BB-1:0]                                     new_acc;
	logic [BB-1:0]                                     marker_val;
	logic [lsbx_pkg::MAX_RESULTS-1:0][BB-1:0]          bytes_w;
	logic                                              hit;
	lsbx_pkg::lsbx_entry_t                             ent;

	always_comb begin
		take    = (bpp_q > 6'd32) ? 6'd32 : bpp_q;
		taken   = pixel_value & PIX_MASK & 32'((33'd1 << take) - 33'd1);
		win     = ({32'd0, acc_q} << take) | {8'd0, taken};
		len     = {3'd0, cnt_q} + take;
		// Left-align the live bits so that byte j sits at a fixed place.
		aligned = win << (6'd40 - len);
		nbytes  = len[5:3];
		new_acc = win[BB-1:0] & 8'((9'd1 << len[2:0]) - 9'd1);
		for (int j = 0; j < int'(lsbx_pkg::MAX_RESULTS); j++) begin
			bytes_w[j] = aligned[WB-1-BB*j -: BB];
		end
		marker_val = captured_q ? marker_q : bytes_w[0];
	end

	// Select the bytes to deliver: the first byte after reset is the marker,
	// and a byte equal to the marker ends the run.
	always_comb begin
		logic [2:0] n;
		n   = 3'd0;
		hit = 1'b0;
		ent = '0;
		for (int j = 0; j < int'(lsbx_pkg::MAX_RESULTS); j++) begin
			if ((3'(j) < nbytes) && (j != 0 || captured_q) && !hit) begin
				ent.data[n[1:0]] = bytes_w[j];
				n = n + 3'd1;
				if (bytes_w[j] == marker_val) begin
					hit = 1'b1;
				end
			end
		end
		ent.count    = n;
		ent.end_flag = hit;
	end

	assign push       = accept && !stopped_q && (ent.count != 3'd0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q      <= 6'd1;
			acc_q      <= '0;
			cnt_q      <= '0;
			marker_q   <= '0;
			captured_q <= 1'b0;
			stopped_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bpp_q <= cfg_wr_data;
			end
			if (accept && !stopped_q) begin
				if (hit) begin
					stopped_q <= 1'b1;
					acc_q     <= '0;
					cnt_q     <= '0;
				end else begin
					acc_q <= new_acc;
					cnt_q <= len[2:0];
				end
				if (!captured_q && nbytes != 3'd0) begin
					captured_q <= 1'b1;
					marker_q   <= bytes_w[0];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_stopped : assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !push)
		else $error("front pushed an entry after the end byte");
	a_end_stops : assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.end_flag) |=> stopped_q)
		else $error("end byte delivered but extraction did not stop");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lsbx_queue.sv
// ----------------------------------------------------------------------------
// lsbx_queue: entry queue between byte assembly and byte delivery
// A small register queue that lets intake and delivery stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire lsbx_pkg::lsbx_entry_t push_entry,
	input  wire logic                  pop,
	output      lsbx_pkg::lsbx_entry_t head,
	output      lsbx_pkg::lsbx_qstat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	lsbx_pkg::lsbx_entry_t store_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      fill_q;

	assign head       = store_q[rd_ptr_q];
	assign stat.full  = (fill_q == CNT_W'(DEPTH));
	assign stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("entry written into a full queue");
	a_no_underflow : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("entry taken from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lsbx_back.sv
// ----------------------------------------------------------------------------
// lsbx_back: byte delivery
// Walks the head entry one byte at a time into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lsbx_pkg::lsbx_entry_t head,
	input  wire lsbx_pkg::lsbx_qstat_t stat,
	output      logic                  pop,
	input  wire logic                  out_stall,
	output      logic                  out_valid,
	output      logic [7:0]            data_byte,
	output      logic                  end_found,
	output      logic                  last_of_run
);

	logic       out_valid_q;
	logic [7:0] data_byte_q;
	logic       end_found_q;
	logic       last_of_run_q;
	logic [1:0] idx_q;
	logic       load;
	logic       last;

	assign load = !stat.empty && (!out_valid_q || !out_stall);
	assign last = ({1'b0, idx_q} == (head.count - 3'd1));
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_byte_q   <= head.data[idx_q];
			end_found_q   <= last && head.end_flag;
			last_of_run_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = data_byte_q;
	assign end_found   = end_found_q;
	assign last_of_run = last_of_run_q;

`ifndef SYNTHESIS
	a_end_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_found_q) |-> last_of_run_q)
		else $error("end byte was not the last byte of its pixel");
`endif

endmodule

`default_nettype wire

FILE: test/lsb_stego_byte_extractor_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_stego_byte_extractor_chk: byte predictor and scoreboard
// Watches the configuration port and both channels of the extractor. It
// predicts the bytes each accepted pixel should release and compares every
// delivered byte, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module lsb_stego_byte_extractor_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] pixel_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_found,
	input  logic        last_of_run,
	output int          mismatches,
	output int          pending,
	output int          bytes_checked
);

	typedef struct packed {
		logic [lsbx_pkg::BYTE_BITS-1:0] data;
		logic                           end_flag;
		logic                           last;
	} hidden_byte_t;

	hidden_byte_t                   expected_bytes[$];
	hidden_byte_t                   oldest;
	logic [lsbx_pkg::BPP_W-1:0]     width_shadow;
	logic [lsbx_pkg::BYTE_BITS-1:0] accum;
	int                             bits_held;
	logic [lsbx_pkg::BYTE_BITS-1:0] marker;
	logic                           marker_held;
	logic                           halted;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_predictor();
		expected_bytes.delete();
		width_shadow = 6'd1;
		accum = '0;
		bits_held = 0;
		marker = '0;
		marker_held = 1'b0;
		halted = 1'b0;
		pending = 0;
	endtask

	// Shifts the pixel's low bits in, most significant first. The byte that
	// ends a pixel's run is held back so that its last flag can be set.
	task automatic extract_bytes(input logic [31:0] pix);
		int           take;
		hidden_byte_t held;
		logic         have_held;
		logic         hit;
		if (halted)
			return;
		take = (width_shadow > lsbx_pkg::MAX_TAKE) ? lsbx_pkg::MAX_TAKE : width_shadow;
		have_held = 1'b0;
		held = '0;
		for (int k = take - 1; k >= 0; k--) begin
			accum = {accum[lsbx_pkg::BYTE_BITS-2:0], pix[k]};
			bits_held++;
			if (bits_held == lsbx_pkg::BYTE_BITS) begin
				bits_held = 0;
				if (!marker_held) begin
					marker = accum;
					marker_held = 1'b1;
				end else begin
					hit = (accum == marker);
					if (have_held)
						expected_bytes.push_back(held);
					held.data = accum;
					held.end_flag = hit;
					held.last = 1'b0;
					have_held = 1'b1;
					if (hit) begin
						// The rest of this pixel is thrown away.
						halted = 1'b1;
						accum = '0;
						break;
					end
				end
				accum = '0;
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			expected_bytes.push_back(held);
		end
	endtask

	initial begin
		mismatches = 0;
		bytes_checked = 0;
		clear_predictor();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_predictor();
		end else begin
			// A pixel taken at the same edge as a register write still sees
			// the old width.
			if (in_valid && !in_stall)
				extract_bytes(pixel_value);
			if (cfg_wr_en)
				width_shadow = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h delivered with none expected",
						data_byte));
				end else begin
					oldest = expected_bytes.pop_front();
					bytes_checked++;
					if (data_byte !== oldest.data)
						report_mismatch($sformatf("data_byte %02h, expected %02h",
							data_byte, oldest.data));
					if (end_found !== oldest.end_flag)
						report_mismatch($sformatf("end_found %b, expected %b on byte %02h",
							end_found, oldest.end_flag, oldest.data));
					if (last_of_run !== oldest.last)
						report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
							last_of_run, oldest.last, oldest.data));
				end
			end
			pending = expected_bytes.size();
		end
	end

endmodule

FILE: test/lsb_stego_byte_extractor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_stego_byte_extractor_tb: top level of the extractor testbench
// Builds pixel streams that hide a known byte sequence at a range of bit
// widths, drives them into the block with random gaps and stalls, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module lsb_stego_byte_extractor_tb;

	// No transaction for this many cycles means the block has hung.
	localparam int IDLE_LIMIT    = 2000;
	// Length of the long receiver hold-off that fills the internal queue.
	localparam int HOLD_CYCLES   = 80;
	// Random pixels that carry data, not counting those at zero width.
	localparam int RANDOM_TARGET = 210;
	// The run ends with this many pixels sent without any idling.
	localparam int QUIET_TAIL    = 40;
	// Bytes pass through the queue and the output register; this wait is ample
	// margin for the queue to drain before a register write or the verdict.
	localparam int DRAIN_CYCLES  = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [5:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] pixel_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic        end_found;
	logic        last_of_run;

	int          mismatches;
	int          pending;
	int          bytes_checked;

	// Stimulus bookkeeping. The hidden bit stream is the sender's own view of
	// the data; it holds whole bytes, so the block's bit position always
	// follows from how many bits are left in it.
	logic        idle_on = 1'b1;
	logic        hold_request = 1'b0;
	logic [5:0]  width_now = 6'd1;
	logic [7:0]  marker_byte;
	logic        hidden_bits[$];
	int          pixels_sent = 0;
	int          width_writes = 0;
	int          quiet_cycles = 0;

	lsb_stego_byte_extractor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.end_found   (end_found),
		.last_of_run (last_of_run)
	);

	lsb_stego_byte_extractor_chk byte_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.end_found     (end_found),
		.last_of_run   (last_of_run),
		.mismatches    (mismatches),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	always #6 clk = ~clk;

	// Appends one byte to the hidden stream, most significant bit first.
	task automatic queue_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--)
			hidden_bits.push_back(b[i]);
	endtask

	// A data byte must never equal the marker, or extraction would stop
	// early; the block cannot be restarted without a second reset.
	function automatic logic [7:0] random_data();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == marker_byte);
		return b;
	endfunction

	// Offers one pixel and returns at the falling edge after the transaction.
	// Valid is left high so that back-to-back pixels need no extra step; any
	// caller that pauses lowers it first. An idle gap may come before the
	// pixel is offered, never while it is waiting.
	task automatic send_pixel(input logic [31:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Takes as many hidden bits as the current width uses and places them in
	// the low end of the pixel, topping the stream up with fresh data bytes
	// when it runs short. The bits above the width are random noise.
	task automatic send_hidden();
		logic [31:0] v;
		int          take;
		take = (width_now > lsbx_pkg::MAX_TAKE) ? lsbx_pkg::MAX_TAKE : width_now;
		while (hidden_bits.size() < take)
			queue_byte(random_data());
		v = $urandom;
		for (int k = take - 1; k >= 0; k--)
			v[k] = hidden_bits.pop_front();
		send_pixel(v);
	endtask

	// The width register is only written once every predicted byte has left
	// and the block has had time to settle. A pixel can complete no byte at
	// all, so an empty scoreboard alone does not prove the block is idle.
	task automatic set_width(input logic [5:0] w);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		width_now = w;
		width_writes++;
	endtask

	// Receiver side. It stalls in short random bursts, and once on request
	// holds off for a long stretch while the sender keeps offering pixels, so
	// that the queue inside the block fills and the input stalls.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int         phase_len;
		int         random_items;
		logic [5:0] w;

		// Neither all zeros nor all ones, so those bytes stay usable as data.
		marker_byte = 8'($urandom_range(1, 254));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. At the reset width of one bit, three pixels carry
		// the first bits of the marker; a single five-bit pixel then
		// completes it, which must deliver nothing at all.
		queue_byte(marker_byte);
		repeat (3) send_hidden();
		set_width(6'd5);
		send_hidden();

		// Byte aligned at full width: an all-zero and an all-ones pixel, each
		// releasing four bytes in one burst.
		set_width(6'd32);
		repeat (4) queue_byte(8'h00);
		send_hidden();
		repeat (4) queue_byte(8'hFF);
		send_hidden();

		// At zero width pixels are accepted but take no bits.
		set_width(6'd0);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);

		// The largest register value behaves as a full 32-bit width.
		set_width(6'd63);
		repeat (2) send_hidden();

		// Odd widths make bytes complete part way through a pixel, with the
		// remaining bits carried into the next byte.
		set_width(6'd13);
		repeat (4) send_hidden();
		set_width(6'd7);
		repeat (3) send_hidden();

		// Random part. The first phase uses a wide setting and asks the
		// receiver for its long hold-off, so the block has to stall its input.
		w = 6'($urandom_range(20, 32));
		set_width(w);
		hold_request = 1'b1;
		repeat (30) send_hidden();
		random_items = 30;

		while (random_items < RANDOM_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					w = 6'd0;
				end
				1: begin
					w = 6'($urandom_range(33, 63));
				end
				default: begin
					w = 6'($urandom_range(1, 32));
				end
			endcase
			phase_len = $urandom_range(8, 30);
			set_width(w);
			repeat (phase_len) begin
				if (random_items >= RANDOM_TARGET - QUIET_TAIL)
					idle_on = 1'b0;
				send_hidden();
				if (w != 0)
					random_items++;
			end
		end

		// Closing phase: the marker comes back inside a full-width pixel,
		// followed by data bits that must be discarded. The pixels after it
		// are accepted and ignored for the rest of the run.
		set_width(6'd32);
		queue_byte(marker_byte);
		repeat (4) queue_byte(random_data());
		send_hidden();
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_hidden();
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Summary: %0d pixels over %0d width settings from 0 to 63, %0d bytes checked,",
			pixels_sent, width_writes, bytes_checked);
		$display("with marker capture, four-byte bursts, a full queue and the stop on the end byte.");
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/lsbx_pkg.sv
rtl/core/lsbx_front.sv
rtl/core/lsbx_queue.sv
rtl/core/lsbx_back.sv
rtl/core/lsb_stego_byte_extractor.sv
test/lsb_stego_byte_extractor_chk.sv
test/lsb_stego_byte_extractor_tb.sv
